// ----- rtl/vpu_pkg.sv -----
// Shared types and widths for the Verlet particle update block.
// Used by the multiplier, the iterative square root / divider and the top level.
`default_nettype none

package vpu_pkg;

    // Signed operand width of the shared multiplier, and its product width
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Iterative unit: operand and result widths
    localparam int ISD_NUM_W = 64;
    localparam int ISD_RES_W = 32;
    localparam int ISD_REM_W = 36;

    typedef enum logic {
        ISD_SQRT,
        ISD_DIV
    } isd_op_t;

    // Request to the iterative unit; operands are sampled when start is high
    typedef struct packed {
        logic                   start;
        isd_op_t                op;
        logic [ISD_NUM_W-1:0]   num;
        logic [ISD_RES_W-1:0]   den;
    } isd_req_t;

    // Response: done pulses for one cycle with the result
    typedef struct packed {
        logic                   done;
        logic [ISD_RES_W-1:0]   result;
    } isd_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/vpu_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on vpu_pkg for the operand and product widths.
`default_nettype none

module vpu_mul (
    input  wire logic                                clk,
    input  wire logic signed [vpu_pkg::MUL_W-1:0]    op_a,
    input  wire logic signed [vpu_pkg::MUL_W-1:0]    op_b,
    output logic signed      [vpu_pkg::PROD_W-1:0]   prod
);

    logic signed [vpu_pkg::PROD_W-1:0] prod_reg;

    // Register the product; the sequencer reads it in the cycle after issue
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/vpu_isd.sv -----
// Iterative unit: floor square root of a 64-bit value or 64/32 division,
// one result bit per cycle through one shared subtractor. Uses vpu_pkg.
`default_nettype none

module vpu_isd (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vpu_pkg::isd_req_t req,
    output vpu_pkg::isd_rsp_t      rsp
);

    logic [vpu_pkg::ISD_NUM_W-1:0] x_reg;
    logic [vpu_pkg::ISD_REM_W-1:0] rem_reg;
    logic [vpu_pkg::ISD_RES_W-1:0] root_reg;
    logic [vpu_pkg::ISD_RES_W-1:0] den_reg;
    vpu_pkg::isd_op_t              op_reg;
    logic [4:0]                    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [vpu_pkg::ISD_REM_W-1:0] rem_sh;
    logic [vpu_pkg::ISD_REM_W-1:0] trial;
    logic [vpu_pkg::ISD_REM_W:0]   diff;
    logic                          ge;

    // Shift in the next digits and form the trial subtrahend
    always_comb
    begin
        unique case (op_reg)
            vpu_pkg::ISD_SQRT:
            begin
                rem_sh = {rem_reg[vpu_pkg::ISD_REM_W-3:0], x_reg[63:62]};
                trial  = {2'b00, root_reg, 2'b01};
            end
            vpu_pkg::ISD_DIV:
            begin
                rem_sh = {3'b000, rem_reg[31:0], x_reg[63]};
                trial  = {4'b0000, den_reg};
            end
            default:
            begin
                rem_sh = '0;
                trial  = '0;
            end
        endcase
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = ~diff[vpu_pkg::ISD_REM_W];
    end

    // Load on start, then one restoring step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= vpu_pkg::ISD_SQRT;
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            den_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd31;
            op_reg   <= req.op;
            den_reg  <= req.den;
            root_reg <= '0;
            if (req.op == vpu_pkg::ISD_SQRT)
            begin
                x_reg   <= req.num;
                rem_reg <= '0;
            end
            else
            begin
                x_reg   <= {req.num[31:0], 32'd0};
                rem_reg <= {4'b0000, req.num[63:32]};
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[vpu_pkg::ISD_REM_W-1:0] : rem_sh;
            root_reg <= {root_reg[vpu_pkg::ISD_RES_W-2:0], ge};
            if (op_reg == vpu_pkg::ISD_SQRT)
                x_reg <= {x_reg[61:0], 2'b00};
            else
                x_reg <= {x_reg[62:0], 1'b0};
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = root_reg;

endmodule

`default_nettype wire

// ----- rtl/verlet_particle_update.sv -----
// Top level: one 3D particle under position Verlet integration, Q16.16.
// Sequencer over vpu_mul (shared multiplier) and vpu_isd (sqrt / divide); uses vpu_pkg.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: vectors, step, pin; s_tuser: mode
//  m_      | out       | m_tvalid/m_tready  | m_tdata: position and cap flags
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A capped vector with a nonzero limit adds a square root and three vpu_isd divisions.
// s_tready is high only while the sequencer is idle; a finished item waits in the
// output register, and the next item is taken meanwhile. Reset restores the register
// defaults and clears the particle state. Config writes are always taken.
`default_nettype none

module verlet_particle_update (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [31:0] vector_x, [63:32] vector_y, [95:64] vector_z,
    // [111:96] step_length, [112] pin_flag, [119:113] zero
    input  wire logic [119:0]  s_tdata,
    // [1:0] mode
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [20:0] pos_x, [40:21] pos_y, [61:41] pos_z, [62] accel_capped, [63] speed_capped
    output logic [63:0]        m_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [30:0]   cfg_data
);

    localparam int PW = vpu_pkg::PROD_W;
    localparam int MW = vpu_pkg::MUL_W;

    localparam logic [30:0] MAX_ACC_RST = 31'd1310720;
    localparam logic [30:0] MAX_SPD_RST = 31'd65536;
    localparam logic [30:0] DAMPING_RST = 31'd655360;
    localparam logic [30:0] INV_MASS_RST = 31'd65536;
    localparam logic [20:0] BOX_XZ = 21'd655360;
    localparam logic [20:0] BOX_Y  = 21'd327680;

    localparam logic [7:0] REG_MAX_ACC  = 8'd0;
    localparam logic [7:0] REG_MAX_SPD  = 8'd1;
    localparam logic [7:0] REG_DAMPING  = 8'd2;
    localparam logic [7:0] REG_INV_MASS = 8'd3;

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_FORCE,
        MODE_STEP,
        MODE_PIN
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FORCE_MUL,
        ST_FORCE_ACC,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_LIM_MUL,
        ST_LIM_CMP,
        ST_SQRT_WAIT,
        ST_SC_MUL,
        ST_SC_DIV,
        ST_DIV_WAIT,
        ST_CAP_DONE,
        ST_K1_MUL,
        ST_K1_STORE,
        ST_K_MUL,
        ST_K_STORE,
        ST_DT_MUL,
        ST_DT_STORE,
        ST_DH_MUL,
        ST_DH_STORE,
        ST_DL_MUL,
        ST_DL_ADJ,
        ST_A_UPD,
        ST_PS_MUL,
        ST_PS_UPD,
        ST_FIN
    } state_t;

    // round(p / 2^16), ties up
    function automatic logic signed [49:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] s;
        begin
            s = p + 66'sd32768;
            rnd16 = s[65:16];
        end
    endfunction

    // round(p / 2^33), ties up
    function automatic logic signed [32:0] rnd33(input logic signed [65:0] p);
        logic signed [65:0] s;
        begin
            s = p + 66'sd4294967296;
            rnd33 = s[65:33];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        begin
            if (v > 66'sd2147483647)
                sat32 = 32'sh7fffffff;
            else if (v < -66'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] clamp_box(input logic signed [35:0] v,
                                                     input logic [20:0] lim);
        logic signed [35:0] hi;
        begin
            hi = $signed({15'd0, lim});
            if (v > hi)
                clamp_box = 32'(hi);
            else if (v < -hi)
                clamp_box = 32'(-hi);
            else
                clamp_box = 32'(v);
        end
    endfunction

    // Configuration
    logic [30:0] max_acc_reg;
    logic [30:0] max_spd_reg;
    logic [30:0] damping_reg;
    logic [30:0] inv_mass_reg;

    // Particle state
    logic signed [31:0] pos_reg  [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] acc_reg  [3];
    logic               pinned_reg;

    // Work registers
    state_t             state_reg;
    logic [1:0]         idx_reg;
    logic               which_reg;
    logic signed [32:0] vec_reg [3];
    logic [30:0]        lim_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        m_reg;
    logic [46:0]        k_reg;
    logic [31:0]        dtsq_reg;
    logic [15:0]        dt_reg;
    logic signed [63:0] t_reg;
    logic               acap_reg;
    logic               scap_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    // Datapath wires
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    vpu_pkg::isd_req_t    isd_req;
    vpu_pkg::isd_rsp_t    isd_rsp;

    logic signed [32:0] vec_sel;
    logic signed [31:0] acc_sel;
    logic signed [31:0] pos_sel;
    logic [32:0]        mag_sel;
    logic signed [49:0] prod_r16;
    logic signed [65:0] force_sum;
    logic signed [35:0] np;
    logic               capped;
    logic [20:0]        box_sel;
    logic signed [31:0] in_vec [3];
    mode_t              in_mode;
    logic               accept;
    logic               out_free;

    assign in_vec[0] = s_tdata[31:0];
    assign in_vec[1] = s_tdata[63:32];
    assign in_vec[2] = s_tdata[95:64];
    assign in_mode   = mode_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Select the component in work
    assign vec_sel   = vec_reg[idx_reg];
    assign acc_sel   = acc_reg[idx_reg];
    assign pos_sel   = pos_reg[idx_reg];
    assign mag_sel   = vec_sel[32] ? 33'(-vec_sel) : 33'(vec_sel);
    assign box_sel   = (idx_reg == 2'd1) ? BOX_Y : BOX_XZ;
    assign capped    = sum_reg > prod[63:0];
    assign prod_r16  = rnd16(prod);
    assign force_sum = 66'(acc_sel) + 66'(prod_r16);
    assign np        = 36'(pos_sel) + 36'(vec_sel) + 36'(rnd33(prod));

    // Route operands to the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FORCE_MUL:
            begin
                mul_a = vec_sel;
                mul_b = $signed({2'b00, inv_mass_reg});
            end
            ST_SQ_MUL:
            begin
                mul_a = $signed(mag_sel);
                mul_b = $signed(mag_sel);
            end
            ST_LIM_MUL:
            begin
                mul_a = $signed({2'b00, lim_reg});
                mul_b = $signed({2'b00, lim_reg});
            end
            ST_SC_MUL:
            begin
                mul_a = $signed(mag_sel);
                mul_b = $signed({2'b00, lim_reg});
            end
            ST_K1_MUL:
            begin
                mul_a = $signed({17'd0, dt_reg});
                mul_b = $signed({2'b00, damping_reg});
            end
            ST_K_MUL:
            begin
                mul_a = $signed({1'b0, k_reg[31:0]});
                mul_b = $signed({2'b00, inv_mass_reg});
            end
            ST_DT_MUL:
            begin
                mul_a = $signed({17'd0, dt_reg});
                mul_b = $signed({17'd0, dt_reg});
            end
            ST_DH_MUL:
            begin
                mul_a = 33'(acc_sel);
                mul_b = $signed({2'b00, k_reg[46:16]});
            end
            ST_DL_MUL:
            begin
                mul_a = 33'(acc_sel);
                mul_b = $signed({17'd0, k_reg[15:0]});
            end
            ST_PS_MUL:
            begin
                mul_a = 33'(acc_sel);
                mul_b = $signed({1'b0, dtsq_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Start the square root after a cap decision, a division per component
    always_comb
    begin
        isd_req.start = ((state_reg == ST_LIM_CMP) && capped && (lim_reg != '0))
                        || (state_reg == ST_SC_DIV);
        isd_req.op    = (state_reg == ST_SC_DIV) ? vpu_pkg::ISD_DIV : vpu_pkg::ISD_SQRT;
        isd_req.num   = (state_reg == ST_SC_DIV) ? (prod[63:0] + {33'd0, m_reg[31:1]})
                                                 : sum_reg;
        isd_req.den   = m_reg;
    end

    vpu_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    vpu_isd u_isd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (isd_req),
        .rsp   (isd_rsp)
    );

    // Sequencer, particle state, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            which_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            max_acc_reg  <= MAX_ACC_RST;
            max_spd_reg  <= MAX_SPD_RST;
            damping_reg  <= DAMPING_RST;
            inv_mass_reg <= INV_MASS_RST;
            pinned_reg   <= 1'b0;
            acap_reg     <= 1'b0;
            scap_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                prev_reg[i] <= '0;
                acc_reg[i]  <= '0;
                vec_reg[i]  <= '0;
            end
            lim_reg  <= '0;
            sum_reg  <= '0;
            m_reg    <= '0;
            k_reg    <= '0;
            dtsq_reg <= '0;
            dt_reg   <= '0;
            t_reg    <= '0;
        end
        else
        begin
            // Configuration writes; unknown indexes drop
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_ACC:  max_acc_reg  <= cfg_data;
                    REG_MAX_SPD:  max_spd_reg  <= cfg_data;
                    REG_DAMPING:  damping_reg  <= cfg_data;
                    REG_INV_MASS: inv_mass_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        acap_reg <= 1'b0;
                        scap_reg <= 1'b0;
                        idx_reg  <= '0;
                        dt_reg   <= s_tdata[111:96];
                        unique case (in_mode)
                            MODE_LOAD:
                            begin
                                pos_reg[0]  <= clamp_box(36'(in_vec[0]), BOX_XZ);
                                pos_reg[1]  <= clamp_box(36'(in_vec[1]), BOX_Y);
                                pos_reg[2]  <= clamp_box(36'(in_vec[2]), BOX_XZ);
                                prev_reg[0] <= clamp_box(36'(in_vec[0]), BOX_XZ);
                                prev_reg[1] <= clamp_box(36'(in_vec[1]), BOX_Y);
                                prev_reg[2] <= clamp_box(36'(in_vec[2]), BOX_XZ);
                                for (int i = 0; i < 3; i++)
                                    acc_reg[i] <= '0;
                                pinned_reg <= s_tdata[112];
                                state_reg  <= ST_FIN;
                            end
                            MODE_FORCE:
                            begin
                                for (int i = 0; i < 3; i++)
                                    vec_reg[i] <= 33'(in_vec[i]);
                                state_reg <= ST_FORCE_MUL;
                            end
                            MODE_PIN:
                            begin
                                pinned_reg <= s_tdata[112];
                                state_reg  <= ST_FIN;
                            end
                            MODE_STEP:
                            begin
                                if (pinned_reg)
                                begin
                                    for (int i = 0; i < 3; i++)
                                        acc_reg[i] <= '0;
                                    state_reg <= ST_FIN;
                                end
                                else
                                begin
                                    for (int i = 0; i < 3; i++)
                                        vec_reg[i] <= 33'(acc_reg[i]);
                                    lim_reg   <= max_acc_reg;
                                    which_reg <= 1'b0;
                                    sum_reg   <= '0;
                                    state_reg <= ST_SQ_MUL;
                                end
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end

                // Force: acc += round(force * inverse_mass), saturated
                ST_FORCE_MUL: state_reg <= ST_FORCE_ACC;
                ST_FORCE_ACC:
                begin
                    acc_reg[idx_reg] <= sat32(force_sum);
                    if (idx_reg == 2'd2)
                        state_reg <= ST_FIN;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_FORCE_MUL;
                    end
                end

                // Sum of squared magnitudes
                ST_SQ_MUL: state_reg <= ST_SQ_ACC;
                ST_SQ_ACC:
                begin
                    sum_reg <= sum_reg + prod[63:0];
                    if (idx_reg == 2'd2)
                        state_reg <= ST_LIM_MUL;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_LIM_MUL: state_reg <= ST_LIM_CMP;

                // Decide the cap; a zero limit zeroes the vector
                ST_LIM_CMP:
                begin
                    idx_reg <= '0;
                    if (capped)
                    begin
                        if (which_reg)
                            scap_reg <= 1'b1;
                        else
                            acap_reg <= 1'b1;
                        if (lim_reg == '0)
                        begin
                            for (int i = 0; i < 3; i++)
                                vec_reg[i] <= '0;
                            state_reg <= ST_CAP_DONE;
                        end
                        else
                            state_reg <= ST_SQRT_WAIT;
                    end
                    else
                        state_reg <= ST_CAP_DONE;
                end
                ST_SQRT_WAIT:
                begin
                    if (isd_rsp.done)
                    begin
                        m_reg     <= isd_rsp.result;
                        state_reg <= ST_SC_MUL;
                    end
                end

                // Rescale each component: round(|c| * limit / m)
                ST_SC_MUL: state_reg <= ST_SC_DIV;
                ST_SC_DIV: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT:
                begin
                    if (isd_rsp.done)
                    begin
                        vec_reg[idx_reg] <= vec_sel[32] ? -$signed({1'b0, isd_rsp.result})
                                                        : $signed({1'b0, isd_rsp.result});
                        if (idx_reg == 2'd2)
                            state_reg <= ST_CAP_DONE;
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_SC_MUL;
                        end
                    end
                end

                // Keep the capped acceleration, then cap the velocity
                ST_CAP_DONE:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    if (!which_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_reg[i] <= vec_reg[i][31:0];
                            vec_reg[i] <= 33'(pos_reg[i]) - 33'(prev_reg[i]);
                        end
                        lim_reg   <= max_spd_reg;
                        which_reg <= 1'b1;
                        state_reg <= ST_SQ_MUL;
                    end
                    else
                        state_reg <= ST_K1_MUL;
                end

                // Damping factor and dt squared
                ST_K1_MUL:   state_reg <= ST_K1_STORE;
                ST_K1_STORE:
                begin
                    k_reg     <= prod_r16[46:0];
                    state_reg <= ST_K_MUL;
                end
                ST_K_MUL:    state_reg <= ST_K_STORE;
                ST_K_STORE:
                begin
                    k_reg     <= prod_r16[46:0];
                    state_reg <= ST_DT_MUL;
                end
                ST_DT_MUL:   state_reg <= ST_DT_STORE;
                ST_DT_STORE:
                begin
                    dtsq_reg  <= prod[31:0];
                    idx_reg   <= '0;
                    state_reg <= ST_DH_MUL;
                end

                // Damp: acc -= acc * khi + round(acc * klo)
                ST_DH_MUL:   state_reg <= ST_DH_STORE;
                ST_DH_STORE:
                begin
                    t_reg     <= prod[63:0];
                    state_reg <= ST_DL_MUL;
                end
                ST_DL_MUL:   state_reg <= ST_DL_ADJ;
                ST_DL_ADJ:
                begin
                    t_reg     <= t_reg + 64'(prod_r16);
                    state_reg <= ST_A_UPD;
                end
                ST_A_UPD:
                begin
                    acc_reg[idx_reg] <= sat32(66'(acc_sel) - 66'(t_reg));
                    state_reg        <= ST_PS_MUL;
                end

                // New position p + v + round(acc * dt^2 / 2^33), boxed
                ST_PS_MUL:   state_reg <= ST_PS_UPD;
                ST_PS_UPD:
                begin
                    prev_reg[idx_reg] <= pos_sel;
                    pos_reg[idx_reg]  <= clamp_box(np, box_sel);
                    if (idx_reg == 2'd2)
                        state_reg <= ST_FIN;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_DH_MUL;
                    end
                end

                // Hand the item to the output register once it is free
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {scap_reg, acap_reg, pos_reg[2][20:0],
                                         pos_reg[1][19:0], pos_reg[0][20:0]};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_isd_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        isd_rsp.done |-> (state_reg == ST_SQRT_WAIT || state_reg == ST_DIV_WAIT))
        else $error("iterative unit finished outside a wait state");

    a_pos_y_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg[1] <= 32'sd327680) && (pos_reg[1] >= -32'sd327680))
        else $error("y position left the box");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_FIN && m_tvalid_reg))
        else $error("finished item overwrote a pending result");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/vpu_tb_pkg.sv -----
// Item codes and register indexes for the particle update testbench.
// Shared by the checker and the testbench top; depends on nothing else.
package vpu_tb_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FORCE = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_PIN   = 2'd3
    } item_mode_t;

    localparam logic [7:0] REG_MAX_ACCEL = 8'd0;
    localparam logic [7:0] REG_MAX_SPEED = 8'd1;
    localparam logic [7:0] REG_DAMPING   = 8'd2;
    localparam logic [7:0] REG_INV_MASS  = 8'd3;

endpackage

// ----- tb/sv/verlet_particle_update_chk.sv -----
// Checker for verlet_particle_update: predicts each position result from the items
// and register writes it sees, and compares the results field by field. Uses vpu_tb_pkg.
module verlet_particle_update_chk
    import vpu_tb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [119:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [63:0]   m_tdata,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint vec3_t [3];

    localparam longint BOX_XZ = 655360;
    localparam longint BOX_Y  = 327680;

    // Particle state and register copies
    longint unsigned lim_accel, lim_speed, damp_coef, inv_mass;
    vec3_t           pos, prev_pos, accel;
    bit              is_pinned;
    logic [63:0]     positions_due [$];

    assign pending = positions_due.size();

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Saturate to the signed 32-bit range
    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a vector down to the limit when its magnitude exceeds it
    function automatic bit limit_vec(inout vec3_t v, input longint unsigned lim);
        longint unsigned mag [3];
        longint unsigned sum, m, q;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            sum += mag[i] * mag[i];
        end
        if (sum <= lim * lim)
            return 1'b0;
        m = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (lim == 0) ? 0 : (mag[i] * lim + m / 2) / m;
            v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic vec3_t box_clamp(vec3_t v);
        vec3_t r;
        r[0] = clip(v[0], BOX_XZ);
        r[1] = clip(v[1], BOX_Y);
        r[2] = clip(v[2], BOX_XZ);
        return r;
    endfunction

    // Advance the particle by one item and return the packed result it implies
    function automatic logic [63:0] advance_particle(item_mode_t mode, logic [119:0] d);
        vec3_t  vin, a, v, np;
        longint dt, k1, k, khi, klo, adj;
        bit     acap, scap;
        acap = 0;
        scap = 0;
        vin[0] = longint'($signed(d[31:0]));
        vin[1] = longint'($signed(d[63:32]));
        vin[2] = longint'($signed(d[95:64]));
        dt = longint'(d[111:96]);
        case (mode)
            MODE_LOAD:
            begin
                pos = box_clamp(vin);
                prev_pos = pos;
                accel = '{0, 0, 0};
                is_pinned = d[112];
            end
            MODE_FORCE:
                for (int i = 0; i < 3; i++)
                    accel[i] = sat_word(accel[i] +
                                        round_shift(vin[i] * longint'(inv_mass), 16));
            MODE_PIN:
                is_pinned = d[112];
            default:
                if (is_pinned)
                    accel = '{0, 0, 0};
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a[i] = accel[i];
                        v[i] = pos[i] - prev_pos[i];
                    end
                    acap = limit_vec(a, lim_accel);
                    scap = limit_vec(v, lim_speed);
                    k1 = round_shift(dt * longint'(damp_coef), 16);
                    k = round_shift(k1 * longint'(inv_mass), 16);
                    khi = k >>> 16;
                    klo = k & 64'hffff;
                    for (int i = 0; i < 3; i++)
                    begin
                        adj = a[i] * khi + round_shift(a[i] * klo, 16);
                        a[i] = a[i] - adj;
                        if (a[i] < -64'sd2147483648)
                            a[i] = -64'sd2147483648;
                        else if (a[i] > 64'sd2147483647)
                            a[i] = 64'sd2147483647;
                        accel[i] = a[i];
                        np[i] = pos[i] + v[i] + round_shift(a[i] * (dt * dt), 33);
                    end
                    prev_pos = pos;
                    pos = box_clamp(np);
                end
        endcase
        return {scap, acap, pos[2][20:0], pos[1][19:0], pos[0][20:0]};
    endfunction

    // Track writes and items, compare results against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] due;
        if (!rst_n)
        begin
            lim_accel = 1310720;
            lim_speed = 65536;
            damp_coef = 655360;
            inv_mass  = 65536;
            pos = '{0, 0, 0};
            prev_pos = '{0, 0, 0};
            accel = '{0, 0, 0};
            is_pinned = 0;
            positions_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_MAX_ACCEL: lim_accel = cfg_data;
                    REG_MAX_SPEED: lim_speed = cfg_data;
                    REG_DAMPING:   damp_coef = cfg_data;
                    REG_INV_MASS:  inv_mass  = cfg_data;
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                if (positions_due.size() == 0)
                begin
                    $error("result with no item pending: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    due = positions_due.pop_front();
                    if (m_tdata[20:0] !== due[20:0])
                    begin
                        $error("pos_x expected %0d got %0d",
                               $signed(due[20:0]), $signed(m_tdata[20:0]));
                        fail_count++;
                    end
                    if (m_tdata[40:21] !== due[40:21])
                    begin
                        $error("pos_y expected %0d got %0d",
                               $signed(due[40:21]), $signed(m_tdata[40:21]));
                        fail_count++;
                    end
                    if (m_tdata[61:41] !== due[61:41])
                    begin
                        $error("pos_z expected %0d got %0d",
                               $signed(due[61:41]), $signed(m_tdata[61:41]));
                        fail_count++;
                    end
                    if (m_tdata[62] !== due[62])
                    begin
                        $error("accel_capped expected %0d got %0d", due[62], m_tdata[62]);
                        fail_count++;
                    end
                    if (m_tdata[63] !== due[63])
                    begin
                        $error("speed_capped expected %0d got %0d", due[63], m_tdata[63]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                positions_due.push_back(advance_particle(item_mode_t'(s_tuser), s_tdata));
        end
    end

endmodule

// ----- tb/sv/verlet_particle_update_tb.sv -----
// Testbench top for verlet_particle_update: drives items in bursts, stalls results,
// writes registers between phases and gives the verdict. Uses vpu_tb_pkg and the checker.
module verlet_particle_update_tb;
    import vpu_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid, s_tready;
    logic [119:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid, m_tready;
    logic [63:0]   m_tdata;
    logic          cfg_valid, cfg_ready;
    logic [7:0]    cfg_index;
    logic [30:0]   cfg_data;
    int            fail_count, pending;
    int            burst_left;
    int            idle_cycles;
    int unsigned   cycle_count;

    verlet_particle_update i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    verlet_particle_update_chk i_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Stall results on a pattern chosen by cycle_count[10:9]
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) == 0);
            2'd2: m_tready <= cycle_count[2];
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("verlet_particle_update_tb NOT OK");
            $finish;
        end
    end

    // Offer one item; hold valid through bursts, drop it for a random gap between them
    task automatic send_item(item_mode_t mode, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vz, logic [15:0] dt, logic pin);
        s_tdata <= {7'd0, pin, dt, vz, vy, vx};
        s_tuser <= mode;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 6));
        end
    endtask

    task automatic write_reg(logic [7:0] idx, logic [30:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every result is back, plus a margin for the sequencer
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    // Mostly values near the box, sometimes anything at all
    function automatic logic [31:0] pick_value(int span);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Load, push, step: a well-formed run with random content, with some noise mixed in
    task automatic run_random(int count);
        int n, nf, ns;
        n = 0;
        while (n < count)
        begin
            send_item(MODE_LOAD, pick_value(12 << 16), pick_value(7 << 16),
                      pick_value(12 << 16), 16'($urandom), ($urandom_range(0, 9) == 0));
            nf = $urandom_range(0, 3);
            ns = $urandom_range(1, 5);
            n += 1 + nf + ns;
            repeat (nf)
                send_item(MODE_FORCE, pick_value(30 << 16), pick_value(30 << 16),
                          pick_value(30 << 16), 16'($urandom), 1'($urandom));
            repeat (ns)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(MODE_PIN, $urandom, $urandom, $urandom, 16'($urandom),
                              ($urandom_range(0, 2) == 0));
                    n++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_item(MODE_FORCE, pick_value(30 << 16), pick_value(30 << 16),
                              pick_value(30 << 16), 16'($urandom), 1'($urandom));
                    n++;
                end
                send_item(MODE_STEP, $urandom, $urandom, $urandom,
                          ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom),
                          1'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_LOAD;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        m_tready <= 1'b0;
        cycle_count = 0;
        idle_cycles = 0;
        burst_left = 3;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: box edges, field extremes, every mode, pinned behavior
        send_item(MODE_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h0, 1'b0);
        send_item(MODE_LOAD, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff, 1'b0);
        send_item(MODE_LOAD, 32'h00010000, 32'hfffe0000, 32'h00008000, 16'h0, 1'b0);
        send_item(MODE_FORCE, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h0, 1'b1);
        send_item(MODE_FORCE, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h0, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
        send_item(MODE_FORCE, 32'h00030000, 32'hfffd0000, 32'h0, 16'h0, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0);
        send_item(MODE_STEP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'h4000, 1'b1);
        send_item(MODE_PIN, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1);
        send_item(MODE_FORCE, 32'h00100000, 32'h00100000, 32'h00100000, 16'h0, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b0);
        send_item(MODE_PIN, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b0);
        send_item(MODE_LOAD, 32'h00020000, 32'h00010000, 32'hfffe0000, 16'h0, 1'b1);
        send_item(MODE_FORCE, 32'h00050000, 32'h0, 32'h0, 16'h0, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b0);
        send_item(MODE_PIN, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
        send_item(MODE_STEP, 32'h0, 32'h0, 32'h0, 16'hffff, 1'b0);
        run_random(60);
        drain();

        // Zero limits: every capped vector collapses
        write_reg(REG_MAX_ACCEL, 31'd0);
        write_reg(REG_MAX_SPEED, 31'd0);
        write_reg(REG_DAMPING, 31'd0);
        write_reg(REG_INV_MASS, 31'd0);
        run_random(70);
        drain();

        // Largest values: saturation in the force and damping paths
        write_reg(REG_MAX_ACCEL, 31'h7fffffff);
        write_reg(REG_MAX_SPEED, 31'h7fffffff);
        write_reg(REG_DAMPING, 31'h7fffffff);
        write_reg(REG_INV_MASS, 31'h7fffffff);
        write_reg(8'($urandom_range(4, 255)), 31'($urandom));
        run_random(70);
        drain();

        // Random moderate settings
        repeat (3)
        begin
            write_reg(REG_MAX_ACCEL, 31'($urandom_range(0, 40 << 16)));
            write_reg(REG_MAX_SPEED, 31'($urandom_range(0, 2 << 16)));
            write_reg(REG_DAMPING, 31'($urandom_range(0, 20 << 16)));
            write_reg(REG_INV_MASS, 31'($urandom_range(0, 4 << 16)));
            write_reg(8'($urandom_range(4, 255)), 31'($urandom));
            run_random(80);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("verlet_particle_update_tb OK");
        else
            $display("verlet_particle_update_tb NOT OK");
        $finish;
    end

endmodule
